// File: design/mppf_pkg.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH framer package
// Shared types and constants for the front, the back and the top level.
// ----------------------------------------------------------------------------
package mppf_pkg;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_QOS         = 2'd0;
    localparam logic [1:0] CFG_RETAIN      = 2'd1;
    localparam logic [1:0] CFG_TOPIC_LEN   = 2'd2;
    localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd3;

    // Packet constants.
    localparam logic [7:0]  HDR_BASE   = 8'h30;
    localparam logic [7:0]  PKT_ID_HI  = 8'h00;
    localparam logic [7:0]  PKT_ID_LO  = 8'h01;
    localparam logic [7:0]  ERR_BYTE   = 8'h00;
    localparam logic [7:0]  VARINT_CONT = 8'h80;
    localparam logic [27:0] RL_MAX     = 28'h0FFFFFFF;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } cmd_kind_t;

    // One classified item. For a start, data_byte holds the fixed header.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data_byte;
        logic [27:0] rem_len;
        logic [15:0] topic_count;
        logic        add_id;
        logic        mark_last;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } out_word_t;

endpackage

// File: design/mppf_fifo.sv
// ----------------------------------------------------------------------------
// Small register FIFO
// Generic first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mppf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    // Flags come straight from the fill count.
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/mppf_front.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH framer front end
// Holds configuration, tracks the open packet and classifies each word.
// ----------------------------------------------------------------------------
module mppf_front
    import mppf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [27:0] cfg_data,
    input  logic        cmd_full,
    output logic        cmd_push,
    output cmd_t        cmd_word
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOPIC,
        PH_PAYLOAD
    } phase_t;

    logic [1:0]  qos_reg;
    logic        retain_reg;
    logic [15:0] topic_count_reg;
    logic [27:0] payload_len_reg;

    phase_t      phase_reg,      phase_next;
    logic [27:0] bytes_left_reg, bytes_left_next;
    logic [27:0] pay_lat_reg,    pay_lat_next;
    logic        id_lat_reg,     id_lat_next;

    logic        accept;
    logic        start_id;
    logic [16:0] head_len;
    logic [28:0] full_len;
    logic        clamp;
    logic [27:0] start_pay;
    logic [27:0] start_rl;
    logic [27:0] left_dec;

    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    // Configuration writes; the port never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qos_reg         <= '0;
            retain_reg      <= 1'b0;
            topic_count_reg <= '0;
            payload_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_QOS:         qos_reg         <= cfg_data[1:0];
                CFG_RETAIN:      retain_reg      <= cfg_data[0];
                CFG_TOPIC_LEN:   topic_count_reg <= cfg_data[15:0];
                CFG_PAYLOAD_LEN: payload_len_reg <= cfg_data;
                default:         qos_reg         <= qos_reg;
            endcase
        end
    end

    // Remaining length of a new packet, with the payload clamped so that the
    // total fits a four-byte varint.
    assign start_id  = (qos_reg != 2'd0);
    assign head_len  = {1'b0, topic_count_reg} + 17'd2 + (start_id ? 17'd2 : 17'd0);
    assign full_len  = {12'b0, head_len} + {1'b0, payload_len_reg};
    assign clamp     = (full_len > {1'b0, RL_MAX});
    assign start_pay = clamp ? (RL_MAX - {11'b0, head_len}) : payload_len_reg;
    assign start_rl  = clamp ? RL_MAX : full_len[27:0];
    assign left_dec  = bytes_left_reg - 28'd1;

    // Classify the word and advance the packet state.
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        pay_lat_next    = pay_lat_reg;
        id_lat_next     = id_lat_reg;

        cmd_word.kind        = CMD_ERROR;
        cmd_word.data_byte   = data_byte;
        cmd_word.rem_len     = start_rl;
        cmd_word.topic_count = topic_count_reg;
        cmd_word.add_id      = 1'b0;
        cmd_word.mark_last   = 1'b0;

        if (operation == OP_START)
        begin
            cmd_word.kind      = CMD_START;
            cmd_word.data_byte = HDR_BASE | {5'b0, qos_reg, retain_reg};
            id_lat_next        = start_id;
            pay_lat_next       = start_pay;
            if (topic_count_reg == 16'd0)
            begin
                cmd_word.add_id    = start_id;
                cmd_word.mark_last = (start_pay == 28'd0);
                phase_next         = (start_pay == 28'd0) ? PH_IDLE : PH_PAYLOAD;
                bytes_left_next    = start_pay;
            end
            else
            begin
                phase_next      = PH_TOPIC;
                bytes_left_next = {12'b0, topic_count_reg};
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TOPIC:
                begin
                    cmd_word.kind = CMD_DATA;
                    if (left_dec == 28'd0)
                    begin
                        cmd_word.add_id    = id_lat_reg;
                        cmd_word.mark_last = (pay_lat_reg == 28'd0);
                        phase_next      = (pay_lat_reg == 28'd0) ? PH_IDLE : PH_PAYLOAD;
                        bytes_left_next = pay_lat_reg;
                    end
                    else
                    begin
                        bytes_left_next = left_dec;
                    end
                end
                PH_PAYLOAD:
                begin
                    cmd_word.kind   = CMD_DATA;
                    bytes_left_next = left_dec;
                    if (left_dec == 28'd0)
                    begin
                        cmd_word.mark_last = 1'b1;
                        phase_next         = PH_IDLE;
                    end
                end
                default:
                begin
                    cmd_word.kind      = CMD_ERROR;
                    cmd_word.data_byte = ERR_BYTE;
                end
            endcase
        end
    end

    // Packet state, updated on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            pay_lat_reg    <= '0;
            id_lat_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            pay_lat_reg    <= pay_lat_next;
            id_lat_reg     <= id_lat_next;
        end
    end

    // An open packet always expects at least one more byte.
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) == (bytes_left_reg == 28'd0))
        else $error("Packet phase and byte count disagree.");

    // A start always hands the back a length that needs the head bytes.
    a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_word.kind == CMD_START) |-> (cmd_word.rem_len >= 28'd2))
        else $error("Start word carries a remaining length below two.");

endmodule

// File: design/mppf_back.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH framer back end
// Expands each classified word into packet bytes, one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module mppf_back
    import mppf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    input  cmd_t      cmd_word,
    input  logic      out_full,
    output logic      cmd_pop,
    output logic      out_push,
    output out_word_t out_word
);

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_VARINT,
        ST_TOPIC_HI,
        ST_TOPIC_LO,
        ST_ID_HI,
        ST_ID_LO
    } state_t;

    state_t      state_reg, state_next;
    logic [27:0] rem_reg,   rem_next;
    logic        advance;
    logic        done;
    logic        more;

    assign advance  = !cmd_empty && !out_full;
    assign out_push = advance;
    assign cmd_pop  = advance && done;
    assign more     = (rem_reg[27:7] != 21'd0);

    // Byte selection for the current step of the head word.
    always_comb
    begin
        state_next        = state_reg;
        rem_next          = rem_reg;
        done              = 1'b0;
        out_word.out_byte = cmd_word.data_byte;
        out_word.last     = 1'b0;
        out_word.error    = 1'b0;

        unique case (state_reg)
            ST_FIRST:
            begin
                unique case (cmd_word.kind)
                    CMD_START:
                    begin
                        rem_next   = cmd_word.rem_len;
                        state_next = ST_VARINT;
                    end
                    CMD_DATA:
                    begin
                        if (cmd_word.add_id)
                        begin
                            state_next = ST_ID_HI;
                        end
                        else
                        begin
                            done          = 1'b1;
                            out_word.last = cmd_word.mark_last;
                        end
                    end
                    default:
                    begin
                        done              = 1'b1;
                        out_word.out_byte = ERR_BYTE;
                        out_word.error    = 1'b1;
                    end
                endcase
            end
            ST_VARINT:
            begin
                out_word.out_byte = (more ? VARINT_CONT : 8'h00) | {1'b0, rem_reg[6:0]};
                rem_next          = {7'b0, rem_reg[27:7]};
                state_next        = more ? ST_VARINT : ST_TOPIC_HI;
            end
            ST_TOPIC_HI:
            begin
                out_word.out_byte = cmd_word.topic_count[15:8];
                state_next        = ST_TOPIC_LO;
            end
            ST_TOPIC_LO:
            begin
                out_word.out_byte = cmd_word.topic_count[7:0];
                if (cmd_word.add_id)
                begin
                    state_next = ST_ID_HI;
                end
                else
                begin
                    done          = 1'b1;
                    out_word.last = cmd_word.mark_last;
                end
            end
            ST_ID_HI:
            begin
                out_word.out_byte = PKT_ID_HI;
                state_next        = ST_ID_LO;
            end
            ST_ID_LO:
            begin
                out_word.out_byte = PKT_ID_LO;
                done              = 1'b1;
                out_word.last     = cmd_word.mark_last;
            end
            default:
            begin
                state_next = ST_FIRST;
            end
        endcase

        if (done)
        begin
            state_next = ST_FIRST;
        end
    end

    // Sequencer state and the varint shift register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FIRST;
            rem_reg   <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    // Varint steps only run while length bits remain.
    a_varint_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VARINT) |-> (rem_reg != 28'd0))
        else $error("Varint step entered with nothing left to encode.");

    // An error word is a lone zero byte that never closes a packet.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_word.error) |->
            (!out_word.last && out_word.out_byte == ERR_BYTE && cmd_pop))
        else $error("Malformed error word.");

    // A word leaves the queue only once its final byte is stored.
    a_pop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_FIRST))
        else $error("Sequencer did not return to the first step after a pop.");

endmodule

// File: design/mqtt_publish_packet_framer_unit.sv
// Each accepted word is registered in the command queue, each result byte in the result
// queue, whose head drives the result ports. Throughput: one data word per cycle while
// neither queue is full; the last topic word also holds the byte sequencer for the packet
// id, and a start word for its head bytes: the back end emits one byte per cycle at most.
// Reset (rst_n low, asynchronous) empties both queues, closes any open packet
// and clears all configuration registers to zero.
// ----------------------------------------------------------------------------
// MQTT PUBLISH packet framer
// Frames PUBLISH packets from start and data words with a decoupled
// classifier front end and a byte sequencer back end.
// ----------------------------------------------------------------------------
module mqtt_publish_packet_framer_unit
    import mppf_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    logic      cmd_push;
    logic      cmd_pop;
    logic      cmd_empty;
    cmd_t      cmd_in;
    cmd_t      cmd_head;
    logic      out_push;
    logic      out_full;
    out_word_t out_in;
    out_word_t out_head;

    assign cfg_ready = 1'b1;

    // Front end: configuration and classification.
    mppf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .operation (operation),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_full  (full),
        .cmd_push  (cmd_push),
        .cmd_word  (cmd_in)
    );

    // Queue of classified words between the two halves.
    mppf_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (full),
        .empty   (cmd_empty)
    );

    // Back end: byte sequencer.
    mppf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_head),
        .out_full  (out_full),
        .cmd_pop   (cmd_pop),
        .out_push  (out_push),
        .out_word  (out_in)
    );

    // Result queue toward the consumer.
    mppf_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_in),
        .rd_en   (pop),
        .rd_data (out_head),
        .full    (out_full),
        .empty   (empty)
    );

    assign out_byte = out_head.out_byte;
    assign last     = out_head.last;
    assign error    = out_head.error;

endmodule

// File: tb/sv/mqtt_publish_packet_framer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MQTT PUBLISH framer testbench
// Drives start and data words into the framer, frames the same packets in a
// behavioral model of its own, and compares every result word field by field.
// A directed table covers the corner cases, then random packets follow with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module mqtt_publish_packet_framer_unit_tb;
    import mppf_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_WORDS  = 230;
    localparam int CALM_AFTER    = 180;
    localparam int BODY_LIMIT    = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_BURST     = 9;

    // Packet framing phase of the model.
    typedef enum logic [1:0] {
        PK_IDLE,
        PK_TOPIC,
        PK_PAYLOAD
    } pkt_phase_t;

    // One row of the directed table: a register write or an input word.
    typedef enum logic {
        ROW_REG,
        ROW_WORD
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_index;
        logic [27:0] reg_value;
        logic        op;
        logic [7:0]  db;
        logic        known;
        out_word_t   known_word;
    } stim_row_t;

    typedef out_word_t burst_t [MAX_BURST];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        operation = OP_START;
    logic [7:0]  data_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        error;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_QOS;
    logic [27:0] cfg_data = 28'd0;

    // Typed expectation that travels with the word being pushed.
    logic        typed_on = 1'b0;
    out_word_t   typed_word = '0;

    // Model copy of the registers and of the packet state.
    logic [1:0]  set_qos = 2'd0;
    logic        set_retain = 1'b0;
    logic [15:0] set_topic_count = 16'd0;
    logic [27:0] set_payload_len = 28'd0;
    pkt_phase_t  pkt_phase = PK_IDLE;
    logic [27:0] pkt_bytes_left = 28'd0;
    logic [27:0] pkt_payload_len = 28'd0;
    logic        pkt_with_id = 1'b0;

    out_word_t   pending_bytes [$];
    stim_row_t   directed_rows [$];
    int          fail_count = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    mqtt_publish_packet_framer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .error     (error),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Counts a mismatch and prints one line for each of the first 40.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // Topic done: insert the packet id if the packet has one, then open the payload or close the packet.
    function automatic int close_topic(inout burst_t words, input int n);
        int k;
        k = n;
        if (pkt_with_id)
        begin
            words[k] = '{PKT_ID_HI, 1'b0, 1'b0};
            k++;
            words[k] = '{PKT_ID_LO, 1'b0, 1'b0};
            k++;
        end
        if (pkt_payload_len == 28'd0)
        begin
            words[k - 1].last = 1'b1;
            pkt_phase = PK_IDLE;
            pkt_bytes_left = 28'd0;
        end
        else
        begin
            pkt_phase = PK_PAYLOAD;
            pkt_bytes_left = pkt_payload_len;
        end
        return k;
    endfunction

    // Frames one accepted input word and returns the result words it causes.
    function automatic int frame_item(input logic op, input logic [7:0] db,
                                      output burst_t words);
        int k;
        logic [31:0] id_len;
        logic [31:0] room;
        logic [31:0] pay;
        logic [31:0] rem;
        logic [7:0]  b;
        k = 0;
        for (int i = 0; i < MAX_BURST; i++)
            words[i] = '0;
        if (op == OP_START)
        begin
            // Latch the packet shape and clamp the payload to the varint range.
            pkt_with_id = (set_qos != 2'd0);
            id_len = pkt_with_id ? 32'd2 : 32'd0;
            room = {4'd0, RL_MAX} - 32'd2 - {16'd0, set_topic_count} - id_len;
            pay = ({4'd0, set_payload_len} > room) ? room : {4'd0, set_payload_len};
            pkt_payload_len = pay[27:0];
            rem = 32'd2 + {16'd0, set_topic_count} + id_len + pay;
            words[k] = '{HDR_BASE | {5'd0, set_qos, set_retain}, 1'b0, 1'b0};
            k++;
            do
            begin
                b = {1'b0, rem[6:0]};
                rem = rem >> 7;
                if (rem != 32'd0)
                    b = b | VARINT_CONT;
                words[k] = '{b, 1'b0, 1'b0};
                k++;
            end while (rem != 32'd0);
            words[k] = '{set_topic_count[15:8], 1'b0, 1'b0};
            k++;
            words[k] = '{set_topic_count[7:0], 1'b0, 1'b0};
            k++;
            if (set_topic_count == 16'd0)
                k = close_topic(words, k);
            else
            begin
                pkt_phase = PK_TOPIC;
                pkt_bytes_left = {12'd0, set_topic_count};
            end
        end
        else if (pkt_phase == PK_TOPIC)
        begin
            words[k] = '{db, 1'b0, 1'b0};
            k++;
            pkt_bytes_left = pkt_bytes_left - 28'd1;
            if (pkt_bytes_left == 28'd0)
                k = close_topic(words, k);
        end
        else if (pkt_phase == PK_PAYLOAD)
        begin
            words[k] = '{db, 1'b0, 1'b0};
            k++;
            pkt_bytes_left = pkt_bytes_left - 28'd1;
            if (pkt_bytes_left == 28'd0)
            begin
                words[k - 1].last = 1'b1;
                pkt_phase = PK_IDLE;
            end
        end
        else
        begin
            words[k] = '{ERR_BYTE, 1'b0, 1'b1};
            k++;
        end
        return k;
    endfunction

    // At each edge: apply register writes, frame accepted words, check results.
    always @(posedge clk)
    begin : frame_tracking
        burst_t    words;
        out_word_t want;
        int        n;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_QOS:         set_qos = cfg_data[1:0];
                    CFG_RETAIN:      set_retain = cfg_data[0];
                    CFG_TOPIC_LEN:   set_topic_count = cfg_data[15:0];
                    CFG_PAYLOAD_LEN: set_payload_len = cfg_data;
                    default:         ;
                endcase
            end
            if (push && !full)
            begin
                n = frame_item(operation, data_byte, words);
                if (typed_on)
                    pending_bytes.push_back(typed_word);
                else
                    for (int i = 0; i < n; i++)
                        pending_bytes.push_back(words[i]);
            end
            if (pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                    report_mismatch("result word with nothing pending", out_byte, 8'h00);
                else
                begin
                    want = pending_bytes.pop_front();
                    if (out_byte !== want.out_byte)
                        report_mismatch("out_byte", out_byte, want.out_byte);
                    if (last !== want.last)
                        report_mismatch("last", {7'd0, last}, {7'd0, want.last});
                    if (error !== want.error)
                        report_mismatch("error", {7'd0, error}, {7'd0, want.error});
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: pop with random stall bursts until the calm tail.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Offers one input word, with an optional gap first, until it is taken.
    task automatic send_word(input logic op, input logic [7:0] db,
                             input logic known, input out_word_t known_word);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        operation <= op;
        data_byte <= db;
        typed_on <= known;
        typed_word <= known_word;
        do
            @(posedge clk);
        while (full);
        words_sent++;
    endtask

    // Stops pushing and waits until every pending result has come out.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one configuration register.
    task automatic write_reg(input logic [1:0] idx, input logic [27:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [27:0] value);
        return '{ROW_REG, idx, value, OP_START, 8'h00, 1'b0, '0};
    endfunction

    function automatic stim_row_t word_row(input logic op, input logic [7:0] db);
        return '{ROW_WORD, CFG_QOS, 28'd0, op, db, 1'b0, '0};
    endfunction

    // A data word with no open packet: a single error word is known up front.
    function automatic stim_row_t stray_row(input logic [7:0] db);
        return '{ROW_WORD, CFG_QOS, 28'd0, OP_DATA, db, 1'b1, '{ERR_BYTE, 1'b0, 1'b1}};
    endfunction

    // Main sequence: reset, directed table, random packets, final drain.
    initial
    begin
        int          base;
        int          pick;
        int          body;
        int          topic;
        logic [27:0] pay;

        // Directed table: stray data after reset, a bare packet, a full packet
        // with packet id, qos 3, the clamped maximum length, abandoned packets,
        // a register change under an open packet and every varint width.
        directed_rows.push_back(stray_row(8'h00));
        directed_rows.push_back(stray_row(8'hFF));
        directed_rows.push_back(word_row(OP_START, 8'hA5));
        directed_rows.push_back(stray_row(8'h3C));
        directed_rows.push_back(reg_row(CFG_QOS, 28'd1));
        directed_rows.push_back(reg_row(CFG_RETAIN, 28'd1));
        directed_rows.push_back(reg_row(CFG_TOPIC_LEN, 28'd2));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd3));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'hFF));
        directed_rows.push_back(word_row(OP_DATA, 8'hAA));
        directed_rows.push_back(word_row(OP_DATA, 8'h55));
        directed_rows.push_back(word_row(OP_DATA, 8'h0F));
        directed_rows.push_back(stray_row(8'hC3));
        directed_rows.push_back(reg_row(CFG_QOS, 28'd3));
        directed_rows.push_back(reg_row(CFG_RETAIN, 28'd0));
        directed_rows.push_back(reg_row(CFG_TOPIC_LEN, 28'd0));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd0));
        directed_rows.push_back(word_row(OP_START, 8'hFF));
        directed_rows.push_back(reg_row(CFG_QOS, 28'd2));
        directed_rows.push_back(reg_row(CFG_RETAIN, 28'd1));
        directed_rows.push_back(reg_row(CFG_TOPIC_LEN, 28'd1));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, RL_MAX));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'h11));
        directed_rows.push_back(word_row(OP_DATA, 8'h22));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'h33));
        directed_rows.push_back(reg_row(CFG_QOS, 28'd0));
        directed_rows.push_back(reg_row(CFG_TOPIC_LEN, 28'd0));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd1));
        directed_rows.push_back(word_row(OP_DATA, 8'h44));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'h66));
        directed_rows.push_back(stray_row(8'h81));
        directed_rows.push_back(reg_row(CFG_RETAIN, 28'd0));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd126));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd16382));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, 28'd2097150));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(reg_row(CFG_QOS, 28'd1));
        directed_rows.push_back(reg_row(CFG_TOPIC_LEN, 28'd65535));
        directed_rows.push_back(reg_row(CFG_PAYLOAD_LEN, RL_MAX));
        directed_rows.push_back(word_row(OP_START, 8'h00));
        directed_rows.push_back(word_row(OP_DATA, 8'h77));

        // Reset, released on a falling edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
                send_word(directed_rows[i].op, directed_rows[i].db,
                          directed_rows[i].known, directed_rows[i].known_word);
        end

        // Random phases: new settings, then a few packets, mostly well formed.
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS)
        begin
            if (words_sent - base >= CALM_AFTER)
                calm = 1'b1;
            settle();
            pick = $urandom_range(0, 9);
            if (pick < 7)
                topic = $urandom_range(0, 4);
            else if (pick < 9)
                topic = $urandom_range(5, 12);
            else
                topic = $urandom_range(0, 65535);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                pay = 28'($urandom_range(0, 6));
            else if (pick < 8)
                pay = 28'($urandom_range(7, 30));
            else if (pick < 9)
                pay = 28'($urandom_range(100, 20000));
            else
                pay = ($urandom_range(0, 1) != 0) ? RL_MAX : 28'($urandom);
            write_reg(CFG_QOS, 28'($urandom_range(0, 3)));
            write_reg(CFG_RETAIN, 28'($urandom_range(0, 1)));
            write_reg(CFG_TOPIC_LEN, 28'(topic));
            write_reg(CFG_PAYLOAD_LEN, pay);

            repeat ($urandom_range(1, 4))
            begin
                pick = $urandom_range(0, 9);
                // Noise: a stray data word ahead of the packet.
                if (pick == 0)
                    send_word(OP_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
                send_word(OP_START, 8'($urandom_range(0, 255)), 1'b0, '0);
                body = topic + int'(pay);
                if (body > BODY_LIMIT)
                    body = $urandom_range(0, 8);
                else if (pick == 1)
                    body = $urandom_range(0, body);
                for (int j = 0; j < body; j++)
                    send_word(OP_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        // Final drain, then the verdict.
        calm = 1'b1;
        @(negedge clk);
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/mppf_pkg.sv
design/mppf_fifo.sv
design/mppf_front.sv
design/mppf_back.sv
design/mqtt_publish_packet_framer_unit.sv
tb/sv/mqtt_publish_packet_framer_unit_tb.sv
